/* rtl/core/amd_pkg.sv */
// Shared constants, types and state codes for the accelerometer motion detector.
package amd_pkg;

  localparam int WINDOW = 20;

  localparam int IN_W      = 13;
  localparam int THR_W     = 19;
  localparam int OUT_L1_W  = 19;
  localparam int OUT_MAG_W = 19;
  localparam int OUT_SUM_W = 18;

  localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int STORE_W = 3 * IN_W;

  // window sum, signed deviation, deviation magnitude, L1 sum
  localparam int SUM_W = IN_W + $clog2(WINDOW);
  localparam int DEV_W = SUM_W + 1;
  localparam int ABS_W = SUM_W;
  localparam int L1_W  = ABS_W + 2;
  localparam int CMP_W = (L1_W > THR_W) ? L1_W : THR_W;

  // squares, their sum and its root
  localparam int PROD_W = 2 * ABS_W;
  localparam int SQ_W   = 2 * ABS_W + 2;
  localparam int RT_W   = ABS_W + 1;
  localparam int RM_W   = RT_W + 2;
  localparam int ITER_W = $clog2(RT_W);

  localparam int SQC_W = 2;
  localparam logic [SQC_W-1:0] SQ_LAST = SQC_W'(3);

  localparam logic signed [DEV_W-1:0] WINDOW_S  = DEV_W'(WINDOW);
  localparam logic [THR_W-1:0]        THR_RESET = THR_W'(160);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEV,
    ST_L1,
    ST_SQ,
    ST_ROOT,
    ST_DONE
  } amd_state_t;

  typedef struct packed {
    logic             warm;
    logic [ABS_W-1:0] ax;
    logic [ABS_W-1:0] ay;
    logic [ABS_W-1:0] az;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
  } win_res_t;

endpackage

/* rtl/core/amd_if.sv */
// Valid/ready channel interfaces for samples and detection results.
interface amd_sample_if import amd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] accel_x;
  logic signed [IN_W-1:0] accel_y;
  logic signed [IN_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface amd_result_if import amd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        warming_up;
  logic                        motion;
  logic [OUT_L1_W-1:0]         l1_deviation;
  logic [OUT_MAG_W-1:0]        magnitude;
  logic signed [OUT_SUM_W-1:0] sum_x;
  logic signed [OUT_SUM_W-1:0] sum_y;
  logic signed [OUT_SUM_W-1:0] sum_z;

  modport source (output valid, output warming_up, output motion, output l1_deviation,
                  output magnitude, output sum_x, output sum_y, output sum_z,
                  input ready);
  modport sink   (input valid, input warming_up, input motion, input l1_deviation,
                  input magnitude, input sum_x, input sum_y, input sum_z,
                  output ready);
endinterface

/* rtl/core/amd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module amd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/amd_window.sv */
// Sample window store, running sums and per-axis deviation registers.
module amd_window import amd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic signed [IN_W-1:0] sx,
  input  logic signed [IN_W-1:0] sy,
  input  logic signed [IN_W-1:0] sz,
  output win_res_t               res
);

  logic [PTR_W-1:0]       wp;
  logic [CNT_W-1:0]       fill;
  logic [STORE_W-1:0]     rdata;
  logic                   warm;
  logic signed [IN_W-1:0] old_x, old_y, old_z;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic                   warm_q;
  logic [ABS_W-1:0]       ax_q, ay_q, az_q;

  function automatic logic [ABS_W-1:0] abs_dev(input logic signed [IN_W-1:0] s,
                                               input logic signed [SUM_W-1:0] sum);
    logic signed [DEV_W-1:0] d;
    d = DEV_W'(s) * WINDOW_S - DEV_W'(sum);
    return ABS_W'(d[DEV_W-1] ? -d : d);
  endfunction

  // read address is the write pointer; data is ready in the cycle after accept
  amd_ram #(.WIDTH(STORE_W), .DEPTH(WINDOW)) u_store (
    .clk   (clk),
    .we    (step),
    .waddr (wp),
    .wdata ({sz, sy, sx}),
    .raddr (wp),
    .rdata (rdata)
  );

  // while filling, the slot at wp has never been written since reset
  assign warm  = fill < CNT_W'(WINDOW);
  assign old_x = warm ? '0 : $signed(rdata[IN_W-1:0]);
  assign old_y = warm ? '0 : $signed(rdata[2*IN_W-1:IN_W]);
  assign old_z = warm ? '0 : $signed(rdata[3*IN_W-1:2*IN_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      fill  <= '0;
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else if (step) begin
      sum_x <= sum_x + SUM_W'(sx) - SUM_W'(old_x);
      sum_y <= sum_y + SUM_W'(sy) - SUM_W'(old_y);
      sum_z <= sum_z + SUM_W'(sz) - SUM_W'(old_z);
      wp    <= (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + PTR_W'(1);
      if (warm) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      warm_q <= warm;
      ax_q   <= abs_dev(sx, sum_x);
      ay_q   <= abs_dev(sy, sum_y);
      az_q   <= abs_dev(sz, sum_z);
    end
  end

  assign res = {warm_q, ax_q, ay_q, az_q, sum_x, sum_y, sum_z};

endmodule

/* rtl/core/amd_isqrt.sv */
// Digit-serial integer square root, two radicand bits per cycle.
module amd_isqrt import amd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [RT_W-1:0]   root
);

  logic                busy;
  logic [ITER_W-1:0]   cnt;
  logic [SQ_W-1:0]     sh;
  logic [RM_W-1:0]     rem;
  logic [RM_W+1:0]     rem_sh;
  logic [RM_W+1:0]     trial;
  logic [RM_W+1:0]     diff;
  logic                ge;

  assign rem_sh = {rem, sh[SQ_W-1 -: 2]};
  assign trial  = (RM_W + 2)'({root, 2'b01});
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == ITER_W'(RT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      sh   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      cnt  <= cnt + ITER_W'(1);
      sh   <= sh << 2;
      rem  <= ge ? RM_W'(diff) : RM_W'(rem_sh);
      root <= {root[RT_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/accel_motion_detector.sv */
// Top level: moving-average motion detector with L1 threshold and root magnitude.
//
//  channel   dir  beat contents
//  sample    in   accel_x, accel_y, accel_z (13-bit signed)
//  result    out  warming_up, motion, l1_deviation, magnitude, sum_x/y/z
//  cfg_wr    in   diff_threshold (19-bit), written whenever cfg_wr_en is high
//
// One sample at a time: accept, window step, L1 compare and output load; with
// motion the squares and the 19-step two-bit-per-cycle root run before the load.
// rst is synchronous; window contents need no clearing, the fill count masks them.
// A finished result waits in the output register; the next sample is still taken.
module accel_motion_detector import amd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  amd_sample_if.sink         sample,
  amd_result_if.source       result
);

  amd_state_t              state, state_next;
  logic [THR_W-1:0]        thr;
  logic signed [IN_W-1:0]  sx, sy, sz;
  win_res_t                win;
  logic                    win_step;
  logic [L1_W-1:0]         l1_sum;
  logic [L1_W-1:0]         l1;
  logic                    motion;
  logic [RT_W-1:0]         mag;
  logic [SQC_W-1:0]        sq_cnt;
  logic [ABS_W-1:0]        sq_sel;
  logic [PROD_W-1:0]       prod;
  logic [SQ_W-1:0]         acc;
  logic [SQ_W-1:0]         acc_next;
  logic                    root_start;
  logic                    root_done;
  logic [RT_W-1:0]         root;
  logic                    out_free;
  logic                    out_load;

  amd_window u_window (
    .clk  (clk),
    .rst  (rst),
    .step (win_step),
    .sx   (sx),
    .sy   (sy),
    .sz   (sz),
    .res  (win)
  );

  amd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (acc_next),
    .done     (root_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  assign l1_sum   = L1_W'(win.ax) + L1_W'(win.ay) + L1_W'(win.az);
  assign out_free = !result.valid || result.ready;
  assign acc_next = acc + SQ_W'(prod);

  always_comb begin
    unique case (sq_cnt)
      SQC_W'(0): sq_sel = win.ax;
      SQC_W'(1): sq_sel = win.ay;
      default:   sq_sel = win.az;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    win_step     = 1'b0;
    root_start   = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV: begin
        win_step   = 1'b1;
        state_next = ST_L1;
      end
      ST_L1: begin
        if (!win.warm && CMP_W'(l1_sum) > CMP_W'(thr)) begin
          state_next = ST_SQ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SQ: begin
        if (sq_cnt == SQ_LAST) begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sx <= sample.accel_x;
      sy <= sample.accel_y;
      sz <= sample.accel_z;
    end
  end

  // squares: one product per cycle, accumulated in the cycle after
  always_ff @(posedge clk) begin
    if (state == ST_L1) begin
      l1     <= win.warm ? '0 : l1_sum;
      motion <= !win.warm && CMP_W'(l1_sum) > CMP_W'(thr);
      mag    <= '0;
      sq_cnt <= '0;
      acc    <= '0;
      prod   <= '0;
    end else if (state == ST_SQ) begin
      sq_cnt <= sq_cnt + SQC_W'(1);
      prod   <= sq_sel * sq_sel;
      acc    <= acc_next;
    end else if (state == ST_ROOT && root_done) begin
      mag <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.warming_up   <= win.warm;
      result.motion       <= motion;
      result.l1_deviation <= OUT_L1_W'(l1);
      result.magnitude    <= OUT_MAG_W'(mag);
      result.sum_x        <= OUT_SUM_W'($signed(win.sum_x));
      result.sum_y        <= OUT_SUM_W'($signed(win.sum_y));
      result.sum_z        <= OUT_SUM_W'($signed(win.sum_z));
    end
  end

  a_accept_to_dev: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == ST_DEV)
    else $error("accepted sample did not start the window step");

  a_root_in_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("square root finished outside the root state");

  a_no_motion_no_mag: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.motion |-> result.magnitude == '0)
    else $error("magnitude nonzero without motion");

  a_warm_quiet: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.warming_up |-> !result.motion && result.l1_deviation == '0)
    else $error("detection reported during warm-up");

endmodule
